FILE: design/sab_pkg.sv
// Package for the suffix automaton builder: sizes, commands and controller types.
// Used by the controller, datapath and core of the block and by the testbench; depends on nothing.
package sab_pkg;
   localparam int Alphabet = 37;
   localparam int MaxNodes = 4096;
   localparam int NodeW = $clog2(MaxNodes);
   localparam int CountW = NodeW + 1;
   localparam int SymW = 6;
   localparam int SymSlots = 64;
   localparam int TransDepth = MaxNodes * SymSlots;
   localparam int TransAw = $clog2(TransDepth);
   localparam logic [CountW-1:0] NoneLink = '1;

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_READ = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef enum logic [15:0] {
      ST_IDLE    = 16'h0001,
      ST_INIT    = 16'h0002,
      ST_NEWRD   = 16'h0004,
      ST_NEWWR   = 16'h0008,
      ST_W1RD    = 16'h0010,
      ST_W1CHK   = 16'h0020,
      ST_QRD     = 16'h0040,
      ST_QCHK    = 16'h0080,
      ST_CPRD    = 16'h0100,
      ST_CPWR    = 16'h0200,
      ST_W2RD    = 16'h0400,
      ST_W2CHK   = 16'h0800,
      ST_FINISH  = 16'h1000,
      ST_RPTRD   = 16'h2000,
      ST_RPTWAIT = 16'h4000,
      ST_RESULT  = 16'h8000
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic latch_req;
      logic init_row;     // write -1 at cur row (or root), slot sweep
      logic root_row;     // row sweep targets the root instead of cur
      logic sweep_clr;    // clear sweep counter
      logic sweep_inc;
      logic rd_last;      // read lengths/link of last
      logic make_cur;     // write len/link of new node, count++
      logic rd_p;         // read trans[p][c], len[p], link[p]
      logic wr_p_cur;     // trans[p][c]=cur; p=link[p]
      logic rd_q;         // read len[q], link[q]
      logic link_cur_zero;
      logic link_cur_q;
      logic make_clone;   // len/link of clone, count++
      logic rd_q_slot;    // read trans[q][sweep]
      logic wr_cl_slot;   // trans[cl][sweep]=data
      logic wr_p_cl;      // trans[p][c]=cl; p=link[p]
      logic finish_clone; // link[q]=cl; link[cur]=cl follows in set_last
      logic set_last;
      logic clear_all;
      logic rd_report;
      logic cap_q;        // q=trans[p][c], plen=len[p]
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic sym_ok;
      logic full;
      logic p_live;
      logic p_none;      // trans[p][c]==-1
      logic p_is_q;      // trans[p][c]==q
      logic q_live;
      logic solid;       // len[p]+1==len[q]
      logic sweep_last;
      logic init_last;
      logic boot;        // root sweep after reset, no result owed
      logic out_busy;
   } stat_type;
endpackage

FILE: design/sab_datapath.sv
// Datapath of the suffix automaton builder: node stores, walk pointers, output register.
// Depends on sab_pkg.
module sab_datapath (
   input  logic clock,
   input  logic reset,
   input  sab_pkg::cmd_type cmd_i,
   output sab_pkg::stat_type stat_o,
   input  logic [1:0] req_cmd,
   input  logic [5:0] req_symbol,
   input  logic [11:0] req_node_index,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [11:0] rsp_last_state,
   output logic [12:0] rsp_node_count,
   output logic [11:0] rsp_node_length,
   output logic signed [12:0] rsp_node_link,
   output logic signed [12:0] rsp_transition_target,
   output logic rsp_cloned,
   output logic rsp_full_res
);
   import sab_pkg::*;

   logic [CountW-1:0] trans_mem [TransDepth];
   logic [NodeW-1:0] len_mem [MaxNodes];
   logic [CountW-1:0] link_mem [MaxNodes];

   logic [1:0] cmd_ff;
   logic [SymW-1:0] sym_ff;
   logic [NodeW-1:0] idx_ff;
   logic [CountW-1:0] count_ff, count_in;
   logic [NodeW-1:0] last_ff, last_in;
   logic [NodeW-1:0] cur_ff, p_ff, q_ff, cl_ff;
   logic [SymW-1:0] sweep_ff;
   logic cloned_ff, full_ff;
   logic [CountW-1:0] trd_ff, lrd_ff;
   logic [NodeW-1:0] nrd_ff;
   logic [NodeW-1:0] plen_ff;
   logic init_ff;

   // trans, length and link memory ports
   logic t_we;
   logic [TransAw-1:0] t_wa, t_ra;
   logic [CountW-1:0] t_wd;
   logic l_we, k_we;
   logic [NodeW-1:0] l_wa, k_wa, n_ra;
   logic [NodeW-1:0] l_wd;
   logic [CountW-1:0] k_wd;

   function automatic logic [TransAw-1:0] taddr(input logic [NodeW-1:0] n,
                                                input logic [SymW-1:0] s);
      taddr = {n, s};
   endfunction

   logic [NodeW-1:0] sel_node;
   always_comb begin
      sel_node = last_ff;
      if (cmd_ff == CMD_READ) sel_node = idx_ff;
   end

   // memory addresses and writes
   always_comb begin
      t_we = 1'b0; t_wa = '0; t_wd = NoneLink; t_ra = taddr(p_ff, sym_ff);
      l_we = 1'b0; l_wa = cur_ff; l_wd = '0;
      k_we = 1'b0; k_wa = cur_ff; k_wd = NoneLink;
      n_ra = p_ff;
      if (cmd_i.init_row) begin
         t_we = 1'b1;
         t_wa = taddr(cmd_i.root_row ? '0 : cur_ff, sweep_ff);
      end
      if (cmd_i.clear_all) begin
         l_we = 1'b1; l_wa = '0; l_wd = '0;
         k_we = 1'b1; k_wa = '0; k_wd = NoneLink;
      end
      if (cmd_i.rd_last) n_ra = last_ff;
      if (cmd_i.make_cur) begin
         l_we = 1'b1; l_wa = cur_ff; l_wd = nrd_ff + 1'b1;
         k_we = 1'b1; k_wa = cur_ff; k_wd = NoneLink;
      end
      if (cmd_i.rd_p) begin
         n_ra = p_ff;
         t_ra = taddr(p_ff, sym_ff);
      end
      if (cmd_i.wr_p_cur) begin
         t_we = 1'b1; t_wa = taddr(p_ff, sym_ff); t_wd = {1'b0, cur_ff};
      end
      if (cmd_i.rd_q) n_ra = q_ff;
      if (cmd_i.link_cur_zero) begin
         k_we = 1'b1; k_wa = cur_ff; k_wd = '0;
      end
      if (cmd_i.link_cur_q) begin
         k_we = 1'b1; k_wa = cur_ff; k_wd = {1'b0, q_ff};
      end
      // the clone takes the next free node, which is count before the increment
      if (cmd_i.make_clone) begin
         l_we = 1'b1; l_wa = count_ff[NodeW-1:0]; l_wd = plen_ff + 1'b1;
         k_we = 1'b1; k_wa = count_ff[NodeW-1:0]; k_wd = lrd_ff;
      end
      if (cmd_i.rd_q_slot) t_ra = taddr(q_ff, sweep_ff);
      if (cmd_i.wr_cl_slot) begin
         t_we = 1'b1; t_wa = taddr(cl_ff, sweep_ff); t_wd = trd_ff;
      end
      if (cmd_i.wr_p_cl) begin
         t_we = 1'b1; t_wa = taddr(p_ff, sym_ff); t_wd = {1'b0, cl_ff};
      end
      if (cmd_i.finish_clone) begin
         l_we = 1'b0;
         k_we = 1'b1; k_wa = q_ff; k_wd = {1'b0, cl_ff};
      end
      if (cmd_i.set_last) begin
         k_we = cloned_ff; k_wa = cur_ff; k_wd = {1'b0, cl_ff};
      end
      if (cmd_i.rd_report) begin
         n_ra = sel_node;
         t_ra = taddr(sel_node, sym_ff);
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (t_we) trans_mem[t_wa] <= t_wd;
      trd_ff <= trans_mem[t_ra];
   end
   always_ff @(posedge clock) begin
      if (l_we) len_mem[l_wa] <= l_wd;
      nrd_ff <= len_mem[n_ra];
   end
   always_ff @(posedge clock) begin
      if (k_we) link_mem[k_wa] <= k_wd;
      lrd_ff <= link_mem[n_ra];
   end

   // control registers
   always_comb begin
      count_in = count_ff;
      last_in = last_ff;
      if (cmd_i.make_cur || cmd_i.make_clone) count_in = count_ff + 1'b1;
      if (cmd_i.set_last) last_in = cur_ff;
      if (cmd_i.clear_all) begin
         count_in = CountW'(1);
         last_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CountW'(1);
         last_ff <= '0;
         init_ff <= 1'b1;
         sweep_ff <= '0;
      end else begin
         count_ff <= count_in;
         last_ff <= last_in;
         if (cmd_i.clear_all) init_ff <= 1'b0;
         if (cmd_i.sweep_clr) sweep_ff <= '0;
         else if (cmd_i.sweep_inc) sweep_ff <= sweep_ff + 1'b1;
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      if (cmd_i.latch_req) begin
         cmd_ff <= req_cmd;
         sym_ff <= req_symbol;
         idx_ff <= req_node_index;
         cloned_ff <= 1'b0;
         full_ff <= stat_o.full;
         cur_ff <= count_ff[NodeW-1:0];
         p_ff <= last_ff;
      end
      if (cmd_i.wr_p_cur || cmd_i.wr_p_cl) p_ff <= lrd_ff[NodeW-1:0];
      if (cmd_i.cap_q) begin
         q_ff <= trd_ff[NodeW-1:0];
         plen_ff <= nrd_ff;
      end
      if (cmd_i.make_clone) begin
         cl_ff <= count_ff[NodeW-1:0];
         cloned_ff <= 1'b1;
      end
   end

   // p-status: live is p_ff valid and link not none; tracked with a flag
   logic p_dead_ff;
   always_ff @(posedge clock) begin
      if (cmd_i.latch_req) p_dead_ff <= 1'b0;
      else if ((cmd_i.wr_p_cur || cmd_i.wr_p_cl) && lrd_ff[CountW-1]) p_dead_ff <= 1'b1;
   end

   always_comb begin
      stat_o.cmd = cmd_ff;
      stat_o.sym_ok = sym_ff < SymW'(Alphabet);
      stat_o.full = (count_ff + CountW'(2)) > CountW'(MaxNodes);
      stat_o.p_live = !p_dead_ff;
      stat_o.p_none = trd_ff[CountW-1];
      stat_o.p_is_q = trd_ff == {1'b0, q_ff};
      stat_o.q_live = !trd_ff[CountW-1] && (trd_ff < count_ff);
      stat_o.solid = (plen_ff + 1'b1) == nrd_ff;
      stat_o.sweep_last = sweep_ff == SymW'(SymSlots - 1);
      stat_o.init_last = sweep_ff == SymW'(SymSlots - 1);
      stat_o.boot = init_ff;
      stat_o.out_busy = rsp_valid && !rsp_ready;
   end

   // output register, loaded straight from the held report read
   logic full_flag;
   logic rep_live;
   assign full_flag = (cmd_ff == CMD_APPEND) && stat_o.sym_ok && full_ff;
   assign rep_live = (cmd_ff != CMD_READ) || ({1'b0, idx_ff} < count_ff);
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (cmd_i.out_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      if (cmd_i.out_load) begin
         rsp_last_state <= last_ff;
         rsp_node_count <= count_ff;
         rsp_node_length <= rep_live ? nrd_ff : '0;
         rsp_node_link <= rep_live ? lrd_ff : NoneLink;
         rsp_transition_target <= (rep_live && stat_o.sym_ok) ? trd_ff : NoneLink;
         rsp_cloned <= cloned_ff;
         rsp_full_res <= full_flag;
      end
   end
endmodule

FILE: design/sab_controller.sv
// Controller state machine of the suffix automaton builder.
// Depends on sab_pkg.
module sab_controller (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  sab_pkg::stat_type stat_i,
   output sab_pkg::cmd_type cmd_o
);
   import sab_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd_o = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            // write the root's row, one slot a cycle
            cmd_o.init_row = 1'b1;
            cmd_o.root_row = 1'b1;
            cmd_o.sweep_inc = 1'b1;
            if (stat_i.init_last) begin
               cmd_o.clear_all = 1'b1;
               state_in = stat_i.boot ? ST_IDLE : ST_RESULT;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_o.latch_req = 1'b1;
               cmd_o.sweep_clr = 1'b1;
               state_in = ST_RPTRD;
            end
         end
         ST_RPTRD: begin
            state_in = ST_RPTRD;
            if (stat_i.cmd == CMD_CLEAR) begin
               cmd_o.sweep_clr = 1'b1;
               state_in = ST_INIT;
            end else if (stat_i.cmd == CMD_APPEND && stat_i.sym_ok && !stat_i.full) begin
               state_in = ST_NEWWR;
            end else begin
               cmd_o.rd_report = 1'b1;
               state_in = ST_RPTWAIT;
            end
         end
         ST_NEWWR: begin
            // clear new row
            cmd_o.init_row = 1'b1;
            cmd_o.sweep_inc = 1'b1;
            cmd_o.rd_last = 1'b1;
            if (stat_i.sweep_last) state_in = ST_NEWRD;
         end
         ST_NEWRD: begin
            cmd_o.make_cur = 1'b1;
            state_in = ST_W1RD;
         end
         ST_W1RD: begin
            cmd_o.rd_p = 1'b1;
            state_in = ST_W1CHK;
         end
         ST_W1CHK: begin
            if (stat_i.p_live && stat_i.p_none) begin
               cmd_o.wr_p_cur = 1'b1;
               state_in = ST_W1RD;
            end else if (!stat_i.p_live || !stat_i.q_live) begin
               cmd_o.link_cur_zero = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd_o.cap_q = 1'b1;
               state_in = ST_QRD;
            end
         end
         ST_QRD: begin
            cmd_o.rd_q = 1'b1;
            state_in = ST_QCHK;
         end
         ST_QCHK: begin
            if (stat_i.solid) begin
               cmd_o.link_cur_q = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd_o.make_clone = 1'b1;
               cmd_o.sweep_clr = 1'b1;
               state_in = ST_CPRD;
            end
         end
         ST_CPRD: begin
            cmd_o.rd_q_slot = 1'b1;
            state_in = ST_CPWR;
         end
         ST_CPWR: begin
            cmd_o.wr_cl_slot = 1'b1;
            cmd_o.sweep_inc = 1'b1;
            state_in = stat_i.sweep_last ? ST_W2RD : ST_CPRD;
         end
         ST_W2RD: begin
            cmd_o.rd_p = 1'b1;
            state_in = ST_W2CHK;
         end
         ST_W2CHK: begin
            if (stat_i.p_live && stat_i.p_is_q) begin
               cmd_o.wr_p_cl = 1'b1;
               state_in = ST_W2RD;
            end else begin
               cmd_o.finish_clone = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd_o.set_last = 1'b1;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            cmd_o.rd_report = 1'b1;
            state_in = ST_RPTWAIT;
         end
         ST_RPTWAIT: begin
            // keep the report addresses steady while the result register is taken
            cmd_o.rd_report = 1'b1;
            if (!stat_i.out_busy) begin
               cmd_o.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_INIT;
      else state_ff <= state_in;
   end
endmodule

FILE: design/suffix_automaton_builder_core.sv
// Suffix automaton builder, one item at a time. Read, unused, refused and out-of-alphabet
// items go straight to the report read; clear sweeps the 64-slot root row; an append
// clears the new row, checks each node on the first suffix-link walk, then checks a
// target, and when a clone is made copies q's 64-slot row and checks each redirect.
// req_ready returns as the result is loaded; a held result stalls the next load.
// After reset, the root row is written before the first item is taken.
// Depends on sab_pkg, sab_controller and sab_datapath.
module suffix_automaton_builder_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_cmd,
   input  logic [5:0] req_symbol,
   input  logic [11:0] req_node_index,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [11:0] rsp_last_state,
   output logic [12:0] rsp_node_count,
   output logic [11:0] rsp_node_length,
   output logic signed [12:0] rsp_node_link,
   output logic signed [12:0] rsp_transition_target,
   output logic rsp_cloned,
   output logic rsp_full_res
);
   import sab_pkg::*;

   cmd_type cmd;
   stat_type stat;

   sab_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .stat_i(stat), .cmd_o(cmd)
   );

   sab_datapath u_dp (
      .clock(clock), .reset(reset), .cmd_i(cmd), .stat_o(stat),
      .req_cmd(req_cmd), .req_symbol(req_symbol), .req_node_index(req_node_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_last_state(rsp_last_state), .rsp_node_count(rsp_node_count),
      .rsp_node_length(rsp_node_length), .rsp_node_link(rsp_node_link),
      .rsp_transition_target(rsp_transition_target),
      .rsp_cloned(rsp_cloned), .rsp_full_res(rsp_full_res)
   );
endmodule

FILE: design/sab_checker.sv
// Port checker for the suffix automaton builder core.
// Depends only on the core's ports; bound to the top level below.
module sab_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [12:0] rsp_node_count,
   input logic rsp_cloned,
   input logic rsp_full_res
);
   // hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");
   // one item in flight
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");
   // flags exclusive
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_cloned && rsp_full_res))
      else $error("clone and full both flagged");
   // store never empty
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_node_count != 13'd0)
      else $error("node count zero");
endmodule

bind suffix_automaton_builder_core sab_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_node_count(rsp_node_count),
   .rsp_cloned(rsp_cloned), .rsp_full_res(rsp_full_res)
);

FILE: dv/sab_checker.sv
// Checker for the suffix automaton builder: watches both channels, keeps its own
// copy of the node store, predicts each result and compares it field by field.
// Depends on sab_pkg.
module sab_monitor (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic [1:0] req_cmd,
   input  logic [5:0] req_symbol,
   input  logic [11:0] req_node_index,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic [11:0] rsp_last_state,
   input  logic [12:0] rsp_node_count,
   input  logic [11:0] rsp_node_length,
   input  logic signed [12:0] rsp_node_link,
   input  logic signed [12:0] rsp_transition_target,
   input  logic rsp_cloned,
   input  logic rsp_full_res,
   output int   errors
);
   import sab_pkg::*;

   typedef struct {
      logic [11:0] last_state;
      logic [12:0] node_count;
      logic [11:0] node_length;
      logic signed [12:0] node_link;
      logic signed [12:0] target;
      logic cloned;
      logic full_res;
   } sam_result_type;

   localparam logic signed [12:0] Absent = -13'sd1;

   logic signed [12:0] edge_mem [0:MaxNodes-1][0:Alphabet-1];
   logic [11:0] len_mem [0:MaxNodes-1];
   logic signed [12:0] link_mem [0:MaxNodes-1];
   int node_total;
   int tail_node;
   sam_result_type pending_results [$];

   function automatic bit is_live(int n);
      return n >= 0 && n < node_total;
   endfunction

   task automatic create_node(int n, int len, int link);
      for (int i = 0; i < Alphabet; i++) edge_mem[n][i] = Absent;
      len_mem[n] = len[11:0];
      link_mem[n] = link[12:0];
   endtask

   task automatic build_root();
      create_node(0, 0, -1);
      node_total = 1;
      tail_node = 0;
   endtask

   // extend the automaton by one symbol; flag a clone
   task automatic extend_by(int c, output bit made_clone);
      int cur;
      int p;
      int q;
      int cl;
      int guard;
      made_clone = 0;
      cur = node_total;
      p = tail_node;
      create_node(cur, len_mem[tail_node] + 1, -1);
      node_total++;
      guard = 0;
      while (is_live(p) && edge_mem[p][c] == Absent && guard < MaxNodes) begin
         edge_mem[p][c] = cur;
         p = link_mem[p];
         guard++;
      end
      if (!is_live(p)) begin
         link_mem[cur] = 0;
      end else begin
         q = edge_mem[p][c];
         if (!is_live(q)) begin
            link_mem[cur] = 0;
         end else if (len_mem[p] + 1 == len_mem[q]) begin
            link_mem[cur] = q;
         end else begin
            cl = node_total;
            node_total++;
            for (int i = 0; i < Alphabet; i++) edge_mem[cl][i] = edge_mem[q][i];
            len_mem[cl] = len_mem[p] + 1;
            link_mem[cl] = link_mem[q];
            guard = 0;
            while (is_live(p) && edge_mem[p][c] == q && guard < MaxNodes) begin
               edge_mem[p][c] = cl;
               p = link_mem[p];
               guard++;
            end
            link_mem[q] = cl;
            link_mem[cur] = cl;
            made_clone = 1;
         end
      end
      tail_node = cur;
   endtask

   task automatic predict_item(logic [1:0] cmd, int sym, int idx);
      sam_result_type r;
      bit made_clone;
      bit refused;
      int shown;
      bit shown_live;
      made_clone = 0;
      refused = 0;
      shown = tail_node;
      shown_live = 1;
      case (cmd)
         CMD_APPEND: begin
            if (sym < Alphabet) begin
               if (node_total + 2 > MaxNodes) refused = 1;
               else extend_by(sym, made_clone);
            end
            shown = tail_node;
         end
         CMD_READ: begin
            shown = idx;
            shown_live = idx < node_total;
         end
         CMD_CLEAR: begin
            build_root();
            shown = tail_node;
         end
         default: shown = tail_node;
      endcase
      r.last_state = tail_node[11:0];
      r.node_count = node_total[12:0];
      r.node_length = 0;
      r.node_link = Absent;
      r.target = Absent;
      if (shown_live) begin
         r.node_length = len_mem[shown];
         r.node_link = link_mem[shown];
         if (sym < Alphabet) r.target = edge_mem[shown][sym];
      end
      r.cloned = made_clone;
      r.full_res = refused;
      pending_results = {pending_results, r};
   endtask

   task automatic compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   // compare each result transfer, then predict each request transfer
   always @(posedge clock) begin
      sam_result_type w;
      if (reset) begin
         build_root();
         pending_results.delete();
         errors = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result transfer with no expected result");
               errors++;
            end else begin
               w = pending_results.pop_front();
               compare_field("last_state", w.last_state, rsp_last_state);
               compare_field("node_count", w.node_count, rsp_node_count);
               compare_field("node_length", w.node_length, rsp_node_length);
               compare_field("node_link", w.node_link, rsp_node_link);
               compare_field("transition_target", w.target, rsp_transition_target);
               compare_field("cloned", w.cloned, rsp_cloned);
               compare_field("full_res", w.full_res, rsp_full_res);
            end
         end
         if (req_valid && req_ready) predict_item(req_cmd, req_symbol, req_node_index);
      end
   end

   // report expectations never met once the run ends
   final begin
      if (pending_results.size() != 0)
         $error("%0d expected results never arrived", pending_results.size());
   end
endmodule

FILE: dv/testbench.sv
// Top of the suffix automaton builder testbench: clock, reset, stimulus, flow
// control and verdict. Depends on sab_pkg, sab_monitor and the block itself.
module testbench;
   import sab_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int QuietLimit = 30000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_cmd;
   logic [5:0] req_symbol;
   logic [11:0] req_node_index;
   logic rsp_valid;
   logic rsp_ready;
   logic [11:0] rsp_last_state;
   logic [12:0] rsp_node_count;
   logic [11:0] rsp_node_length;
   logic signed [12:0] rsp_node_link;
   logic signed [12:0] rsp_transition_target;
   logic rsp_cloned;
   logic rsp_full_res;
   int errors;

   int sent_count;
   int done_count;
   int quiet_cycles;
   bit gaps_on;
   bit hold_off_req;
   int hold_left;

   suffix_automaton_builder_core uut (.*);

   sab_monitor checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // count transfers and watch for a stuck run
   always @(posedge clock) begin
      if (reset) begin
         sent_count <= 0;
         done_count <= 0;
         quiet_cycles <= 0;
      end else begin
         if (req_valid && req_ready) sent_count <= sent_count + 1;
         if (rsp_valid && rsp_ready) done_count <= done_count + 1;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QuietLimit) begin
            $display("Regression FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off counted here
   initial begin
      bit hold_taken;
      hold_taken = 0;
      rsp_ready = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_taken) begin
            hold_left = 600;
            hold_taken = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= !(gaps_on && $urandom_range(0, 99) < 8);
         end
      end
   end

   // offer one item and hold it until the transfer
   task automatic send_item(logic [1:0] cmd, int sym, int idx);
      @(negedge clock);
      while (gaps_on && $urandom_range(0, 99) < 8) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_symbol <= sym[5:0];
      req_node_index <= idx[11:0];
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 0;
      while (done_count != sent_count) @(negedge clock);
   endtask

   initial begin
      int pick;
      req_valid = 0;
      req_cmd = CMD_APPEND;
      req_symbol = 0;
      req_node_index = 0;
      gaps_on = 0;
      hold_off_req = 0;
      reset = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: root reads, field extremes, unused and out-of-alphabet items
      send_item(CMD_READ, 0, 0);
      send_item(CMD_READ, 36, 0);
      send_item(CMD_READ, 63, 4095);
      send_item(CMD_UNUSED, 5, 7);
      send_item(CMD_APPEND, 37, 0);
      send_item(CMD_APPEND, 63, 4095);
      // "abb" forces a clone, then read back around it
      send_item(CMD_APPEND, 0, 0);
      send_item(CMD_APPEND, 1, 0);
      send_item(CMD_APPEND, 1, 0);
      send_item(CMD_APPEND, 36, 0);
      for (int n = 0; n < 6; n++) send_item(CMD_READ, n % 2, n);
      send_item(CMD_READ, 36, 2);
      send_item(CMD_READ, 1, 4095);
      send_item(CMD_CLEAR, 0, 0);
      send_item(CMD_READ, 0, 1);
      send_item(CMD_APPEND, 0, 0);
      send_item(CMD_APPEND, 0, 0);
      send_item(CMD_APPEND, 2, 0);
      send_item(CMD_READ, 0, 4095);
      send_item(CMD_CLEAR, 0, 0);

      // random traffic: mostly appends over a small alphabet, with reads, unused items and clears
      gaps_on = 1;
      for (int n = 0; n < 1430; n++) begin
         if (n == 400) hold_off_req = 1;
         if (n == 402) hold_off_req = 0;
         if (n == 800) drain_results();
         if (n == 1100) gaps_on = 0;
         if (n == 1250) gaps_on = 1;
         pick = $urandom_range(0, 99);
         if (pick < 55)
            send_item(CMD_APPEND, $urandom_range(0, 3), $urandom_range(0, 4095));
         else if (pick < 60)
            send_item(CMD_APPEND, $urandom_range(0, 63), $urandom_range(0, 4095));
         else if (pick < 85)
            send_item(CMD_READ, $urandom_range(0, 4), $urandom_range(0, 40));
         else if (pick < 93)
            send_item(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 4095));
         else if (pick < 96)
            send_item(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 4095));
         else
            send_item(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 4095));
      end

      drain_results();
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
